@@ rtl/core/lrur_pkg.sv @@
// Package for the LRU replacement list: transaction types and command/status codes.
`timescale 1ns / 1ps

package lrur_pkg;

    localparam int CMD_W    = 2;
    localparam int KEY_W    = 32;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 5;

    localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
    localparam logic [CMD_W-1:0] CMD_EVICT  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_ERASE  = 2'd2;

    localparam logic [STATUS_W-1:0] ST_OK   = 2'd0;
    localparam logic [STATUS_W-1:0] ST_MISS = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL = 2'd2;

    typedef struct packed {
        logic [CMD_W-1:0] cmd;
        logic [KEY_W-1:0] key;
    } lrur_req_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [KEY_W-1:0]    victim_key;
        logic [COUNT_W-1:0]  count;
    } lrur_rsp_t;

endpackage

@@ rtl/core/lru_replacer_core.sv @@
// Top level of the LRU replacement list: command register, list update and result register.
`timescale 1ns / 1ps

// LRU replacement list.
// Holds up to CAPACITY distinct keys ordered by recency: slot 0 is the least
// recent, slot count-1 the most recent.
// Command channel: a transaction is taken on a rising edge with start high and
// busy low. busy is never raised, so one command may be issued every cycle.
// Commands: insert/touch moves or appends a key at the recent end (a new key
// into a full list is refused with status full); evict removes slot 0 and
// returns it; erase removes a given key.
// Result channel: done is high for exactly one cycle with the result fields;
// there is no back-pressure, the receiver must take it in that cycle.
// A taken command is held in the command register; its result is built from
// it and the list. Throughput: one command per cycle, set by the single
// pass of key compare, shift and write between the command register and the
// result register; the list state is updated at the same edge as the result,
// so back-to-back commands see each other's effect.
// Reset: the list is emptied at once (fill count to zero); key slots are not
// cleared, as slots at or above the count are never read. No clearing pass.
// Keys are matched and stored on their low KEY_BITS bits (at most 32).
module lru_replacer_core #(
    parameter int CAPACITY = 16,
    parameter int KEY_BITS = 32
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  lrur_pkg::lrur_req_t request,
    output logic                done,
    output lrur_pkg::lrur_rsp_t result
);

    import lrur_pkg::*;

    // stored key width: the port carries 32 bits, so wider keys add nothing
    localparam int SK_W  = (KEY_BITS < KEY_W) ? KEY_BITS : KEY_W;
    localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(CAPACITY);

    // command register
    logic      in_vld_reg;
    lrur_req_t req_reg;

    // list state
    logic [CAPACITY-1:0][SK_W-1:0] slot_reg;
    logic [CAPACITY-1:0][SK_W-1:0] slot_next;
    logic [CNT_W-1:0]              held_reg;
    logic [CNT_W-1:0]              held_next;

    // result register
    logic      done_reg;
    lrur_rsp_t rsp_reg;
    lrur_rsp_t rsp_next;

    logic                accept;
    logic [SK_W-1:0]     key_k;
    logic                hit;
    logic [CAPACITY-1:0] match;
    logic [CAPACITY-1:0] tail;
    logic [CAPACITY-1:0] shift;
    logic                wr_en;
    logic [IDX_W-1:0]    wr_idx;

    assign busy   = 1'b0;
    assign accept = start && !busy;
    assign key_k  = SK_W'(req_reg.key);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg <= 1'b0;
        end
        else
        begin
            in_vld_reg <= accept;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            req_reg <= request;
        end
    end

    lrur_match #(
        .CAPACITY (CAPACITY),
        .SK_W     (SK_W),
        .CNT_W    (CNT_W)
    ) u_match (
        .slots (slot_reg),
        .held  (held_reg),
        .key   (key_k),
        .hit   (hit),
        .match (match),
        .tail  (tail)
    );

    // command decode: which slots shift down, where a key is written, new count
    always_comb
    begin
        shift               = '0;
        wr_en               = 1'b0;
        wr_idx              = IDX_W'(held_reg);
        held_next           = held_reg;
        rsp_next.status     = ST_OK;
        rsp_next.victim_key = '0;
        unique case (req_reg.cmd)
            CMD_INSERT:
            begin
                if (hit)
                begin
                    // touch: close the gap, re-append at the recent end
                    shift  = tail;
                    wr_en  = 1'b1;
                    wr_idx = IDX_W'(held_reg - 1'b1);
                end
                else if (held_reg >= FULL_CNT)
                begin
                    rsp_next.status = ST_FULL;
                end
                else
                begin
                    wr_en     = 1'b1;
                    held_next = held_reg + 1'b1;
                end
            end
            CMD_EVICT:
            begin
                if (held_reg == '0)
                begin
                    rsp_next.status = ST_MISS;
                end
                else
                begin
                    rsp_next.victim_key = KEY_W'(slot_reg[0]);
                    shift               = '1;
                    held_next           = held_reg - 1'b1;
                end
            end
            CMD_ERASE:
            begin
                if (hit)
                begin
                    shift     = tail;
                    held_next = held_reg - 1'b1;
                end
                else
                begin
                    rsp_next.status = ST_MISS;
                end
            end
            default:
            begin
                // unused code: no operation
            end
        endcase
        if (!in_vld_reg)
        begin
            shift     = '0;
            wr_en     = 1'b0;
            held_next = held_reg;
        end
        rsp_next.count = COUNT_W'(held_next);
    end

    // per-slot next value: shift down from the neighbour, then the append write
    for (genvar g = 0; g < CAPACITY; g++)
    begin : g_slot
        logic [SK_W-1:0] moved;
        if (g < CAPACITY - 1)
        begin : g_shift
            assign moved = shift[g] ? slot_reg[g+1] : slot_reg[g];
        end
        else
        begin : g_top
            assign moved = slot_reg[g];
        end
        assign slot_next[g] = (wr_en && (wr_idx == IDX_W'(g))) ? key_k : moved;
    end

    always_ff @(posedge clk)
    begin
        slot_reg <= slot_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_reg <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            held_reg <= held_next;
            done_reg <= in_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_vld_reg)
        begin
            rsp_reg <= rsp_next;
        end
    end

    assign done   = done_reg;
    assign result = rsp_reg;

`ifndef SYNTHESIS
    // keys are distinct, so at most one live slot can match
    a_match_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        in_vld_reg |-> $onehot0(match))
        else $error("lru list: key held in more than one slot");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        held_reg <= FULL_CNT)
        else $error("lru list: fill count above capacity");

    // a refused insert leaves the list full
    a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
        (done && result.status == ST_FULL) |-> (held_reg == FULL_CNT))
        else $error("lru list: full status while list not full");
`endif

endmodule

@@ rtl/core/lrur_match.sv @@
// Parallel key match over the held slots, with the shift mask for removing the hit.
`timescale 1ns / 1ps

module lrur_match #(
    parameter int CAPACITY = 16,
    parameter int SK_W     = 32,
    parameter int CNT_W    = 5
) (
    input  logic [CAPACITY-1:0][SK_W-1:0] slots,
    input  logic [CNT_W-1:0]              held,
    input  logic [SK_W-1:0]               key,
    output logic                          hit,
    output logic [CAPACITY-1:0]           match,
    output logic [CAPACITY-1:0]           tail
);

    // only slots below the fill count hold live keys
    always_comb
    begin
        for (int i = 0; i < CAPACITY; i++)
        begin
            match[i] = (held > CNT_W'(i)) && (slots[i] == key);
        end
    end

    assign hit = |match;

    // tail: the hit slot and every slot above it move down one place
    for (genvar g = 0; g < CAPACITY; g++)
    begin : g_tail
        assign tail[g] = |match[g:0];
    end

endmodule

@@ test/tb_lru_replacer_core.sv @@
// Testbench for lru_replacer_core: queued command driver, result monitor and recency-list predictor.
`timescale 1ns / 1ps

module tb_lru_replacer_core;

    import lrur_pkg::*;

    localparam int CAPACITY     = 16;
    localparam int KEY_BITS     = 32;
    localparam int RANDOM_ITEMS = 1950;
    localparam int POOL_SIZE    = 24;
    localparam int DRAIN_CYCLES = 8;
    localparam int CYCLE_LIMIT  = 200000;

    // unused command code, behaves as a no-op
    localparam logic [CMD_W-1:0] CMD_NOP = 2'd3;

    logic      clk;
    logic      rst_n = 1'b0;
    logic      start = 1'b0;
    logic      busy;
    lrur_req_t request = '0;
    logic      done;
    lrur_rsp_t result;

    lru_replacer_core #(
        .CAPACITY(CAPACITY),
        .KEY_BITS(KEY_BITS)
    ) DUT (
        .clk(clk),
        .rst_n(rst_n),
        .start(start),
        .busy(busy),
        .request(request),
        .done(done),
        .result(result)
    );

    // Commands waiting to be issued, and results owed by the block.
    lrur_req_t pending_cmds[$];
    lrur_rsp_t owed_results[$];

    // Shadow recency list: entry 0 is least recent.
    logic [KEY_W-1:0] shadow_keys[CAPACITY];
    int               shadow_fill = 0;

    logic [KEY_W-1:0] key_pool[POOL_SIZE];

    int   err_count   = 0;
    int   cycle_count = 0;
    logic taken       = 1'b0;   // a transaction was accepted at the last rising edge
    int   burst_left  = 1;
    int   gap_left    = 0;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    task automatic note_mismatch(input string what, input logic [KEY_W-1:0] got,
                                 input logic [KEY_W-1:0] want);
        $display("mismatch %s: got %0h, expected %0h at %0t", what, got, want, $time);
        err_count++;
    endtask

    task automatic drop_entry(input int pos);
        for (int i = pos; i + 1 < shadow_fill; i++)
            shadow_keys[i] = shadow_keys[i + 1];
        shadow_fill--;
    endtask

    // Applies one command to the shadow list and works out its result.
    task automatic apply_to_shadow(input lrur_req_t req, output lrur_rsp_t rsp);
        int hit;
        hit = -1;
        rsp = '0;
        rsp.status = ST_OK;
        for (int i = 0; i < shadow_fill; i++)
            if (hit < 0 && shadow_keys[i] == req.key)
                hit = i;
        case (req.cmd)
            CMD_INSERT:
            begin
                if (hit >= 0)
                begin
                    drop_entry(hit);
                    shadow_keys[shadow_fill] = req.key;
                    shadow_fill++;
                end
                else if (shadow_fill >= CAPACITY)
                    rsp.status = ST_FULL;
                else
                begin
                    shadow_keys[shadow_fill] = req.key;
                    shadow_fill++;
                end
            end
            CMD_EVICT:
            begin
                if (shadow_fill == 0)
                    rsp.status = ST_MISS;
                else
                begin
                    rsp.victim_key = shadow_keys[0];
                    drop_entry(0);
                end
            end
            CMD_ERASE:
            begin
                if (hit >= 0)
                    drop_entry(hit);
                else
                    rsp.status = ST_MISS;
            end
            default: ;
        endcase
        rsp.count = shadow_fill[COUNT_W-1:0];
    endtask

    task automatic queue_cmd(input logic [CMD_W-1:0] cmd, input logic [KEY_W-1:0] key);
        lrur_req_t req;
        req.cmd = cmd;
        req.key = key;
        pending_cmds.push_back(req);
    endtask

    // Driver: changes inputs on the falling edge. Issues in bursts with idle gaps;
    // while idle the request bus carries junk that the block must ignore.
    always @(negedge clk)
    begin
        logic      next_start;
        lrur_req_t next_req;
        next_start = start;
        next_req   = request;
        if (rst_n && !(start && !taken))
        begin
            next_start   = 1'b0;
            next_req.cmd = CMD_W'($urandom);
            next_req.key = $urandom;
            if (gap_left > 0)
                gap_left--;
            else if (pending_cmds.size() != 0)
            begin
                next_req   = pending_cmds.pop_front();
                next_start = 1'b1;
                burst_left--;
                if (burst_left <= 0)
                begin
                    burst_left = $urandom_range(1, 40);
                    // roughly a third of gaps are empty, giving long back-to-back runs
                    gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
                end
            end
        end
        start   <= next_start;
        request <= next_req;
    end

    // Monitor: samples on the rising edge. Checks the result first, then predicts
    // from any transaction accepted at the same edge.
    always @(posedge clk)
    begin
        lrur_rsp_t want;
        if (!rst_n)
            taken <= 1'b0;
        else
        begin
            if (done)
            begin
                if (owed_results.size() == 0)
                    note_mismatch("unexpected result, victim_key", result.victim_key, '0);
                else
                begin
                    want = owed_results.pop_front();
                    if (result.status !== want.status)
                        note_mismatch("status", KEY_W'(result.status), KEY_W'(want.status));
                    if (result.victim_key !== want.victim_key)
                        note_mismatch("victim_key", result.victim_key, want.victim_key);
                    if (result.count !== want.count)
                        note_mismatch("count", KEY_W'(result.count), KEY_W'(want.count));
                end
            end
            if (start && !busy)
            begin
                apply_to_shadow(request, want);
                owed_results.push_back(want);
            end
            taken <= start && !busy;
        end
    end

    // Watchdog: cycle counter with a generous ceiling.
    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("simulation failed");
        $finish;
    end

    initial
    begin
        int               n;
        int               phase_len;
        int               mode;
        int               roll;
        logic [KEY_W-1:0] k;

        // Directed: empty list, no-op code, extreme keys, touch, fill to capacity,
        // rejected insert, touch while full, erase miss and hit, evict.
        queue_cmd(CMD_EVICT, 32'h0000_0000);
        queue_cmd(CMD_ERASE, 32'hFFFF_FFFF);
        queue_cmd(CMD_NOP, 32'hA5A5_5A5A);
        queue_cmd(CMD_INSERT, 32'h0000_0000);
        queue_cmd(CMD_INSERT, 32'hFFFF_FFFF);
        queue_cmd(CMD_INSERT, 32'h0000_0000);
        for (int i = 0; i < CAPACITY - 2; i++)
            queue_cmd(CMD_INSERT, 32'h8000_0000 >> i);
        queue_cmd(CMD_INSERT, 32'h1234_5678);
        queue_cmd(CMD_INSERT, 32'h0000_0000);
        queue_cmd(CMD_NOP, 32'h0000_0000);
        queue_cmd(CMD_ERASE, 32'h5555_5555);
        queue_cmd(CMD_ERASE, 32'hFFFF_FFFF);
        queue_cmd(CMD_EVICT, 32'hFFFF_FFFF);

        // Keys come mostly from a small pool so touches, hits and a full list are common.
        key_pool[0] = 32'h0000_0000;
        key_pool[1] = 32'hFFFF_FFFF;
        for (int i = 2; i < POOL_SIZE; i++)
            key_pool[i] = $urandom;

        // Random: phases that lean towards filling, draining or a mix.
        n = 0;
        while (n < RANDOM_ITEMS)
        begin
            phase_len = $urandom_range(10, 60);
            mode      = $urandom_range(0, 2);
            for (int j = 0; j < phase_len && n < RANDOM_ITEMS; j++)
            begin
                roll = $urandom_range(0, 99);
                k    = ($urandom_range(0, 9) == 0) ? $urandom
                                                   : key_pool[$urandom_range(0, POOL_SIZE - 1)];
                if (roll < 3)
                    queue_cmd(CMD_NOP, $urandom);
                else if (mode == 0)
                    queue_cmd(roll < 80 ? CMD_INSERT : (roll < 90 ? CMD_EVICT : CMD_ERASE), k);
                else if (mode == 1)
                    queue_cmd(roll < 30 ? CMD_INSERT : (roll < 65 ? CMD_EVICT : CMD_ERASE), k);
                else
                    queue_cmd(roll < 50 ? CMD_INSERT : (roll < 75 ? CMD_EVICT : CMD_ERASE), k);
                n++;
            end
            // occasionally swap a pool entry so fresh keys keep arriving
            if ($urandom_range(0, 3) == 0)
                key_pool[$urandom_range(2, POOL_SIZE - 1)] = $urandom;
        end

        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Drain: every command issued and accepted, every result in.
        while (pending_cmds.size() != 0 || start || owed_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (err_count == 0 && owed_results.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
